// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/mfmc_pkg.sv -----
// shared constants and types for the max flow engine
`default_nettype none
package mfmc_pkg;

  localparam int NODES_DEF = 64;
  localparam int CAP_W     = 17;
  localparam int FLOW_W    = 22;
  localparam int NODE_FW   = 6;
  localparam int MASK_W    = 64;
  localparam int IN_DW     = 40;
  localparam int OUT_DW    = 88;

  localparam logic [CAP_W-1:0]  CAP_MAX  = 17'h1ffff;
  localparam logic [FLOW_W-1:0] FLOW_MAX = 22'h3fffff;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_MIN      = 2'd0,
    OP_SUB      = 2'd1,
    OP_ADD_CAP  = 2'd2,
    OP_ADD_FLOW = 2'd3
  } alu_op_t;

endpackage
`default_nettype wire

// ----- rtl/mfmc_alu.sv -----
// shared min / subtract / saturating add unit
`default_nettype none
module mfmc_alu (
  input  var mfmc_pkg::alu_op_t               op,
  input  wire logic [mfmc_pkg::FLOW_W-1:0]    a,
  input  wire logic [mfmc_pkg::FLOW_W-1:0]    b,
  output logic      [mfmc_pkg::FLOW_W-1:0]    y
);
  import mfmc_pkg::*;

  logic [FLOW_W:0] sum;

  always_comb begin
    sum = {1'b0, a} + {1'b0, b};
    unique case (op)
      OP_MIN:      y = (a < b) ? a : b;
      OP_SUB:      y = a - b;
      OP_ADD_CAP:  y = (sum > {6'd0, CAP_MAX}) ? {5'd0, CAP_MAX} : sum[FLOW_W-1:0];
      OP_ADD_FLOW: y = (sum > {1'b0, FLOW_MAX}) ? FLOW_MAX : sum[FLOW_W-1:0];
      default:     y = a;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/mfmc_mat_ram.sv -----
// capacity matrix ram, one write and one registered read port
`default_nettype none
module mfmc_mat_ram #(
  parameter int AW = 12,
  parameter int DW = 17
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [(1 << AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/max_flow_min_cut_engine_unit.sv -----
// top level: edmonds-karp max flow engine with min cut report
// add edge: written as it is accepted; clear: a sweep of 2^(2*clog2(NODES)) entries (4096 at 64 nodes)
// run: data dependent; each bfs seeds the queue with the source, then reads the matrix row of each
//   popped node; each path is walked back from the sink, updating both entries of each edge; then a report
// the matrix ram port is the limit: one entry read or written per cycle
// after rst a clearing pass over every matrix entry runs with s_tready low
`default_nettype none
module max_flow_min_cut_engine_unit #(
  parameter int NODES = mfmc_pkg::NODES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // from_node[5:0], to_node[11:6], edge_capacity[27:12], source_node[33:28],
  // sink_node[39:34]
  input  wire logic [mfmc_pkg::IN_DW-1:0]    s_tdata,
  // command[1:0]
  input  wire logic [1:0]                    s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // flow_total[21:0], cut_side_mask[85:22], zero pad[87:86]
  output logic      [mfmc_pkg::OUT_DW-1:0]   m_tdata
);
  import mfmc_pkg::*;

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int AW = 2 * NW;
  localparam logic [NW-1:0] VLAST = NW'(NODES - 1);
  localparam logic [NW:0]   NCNT  = (NW + 1)'(NODES);

  // sequencer states
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_INIT  = 4'd2;
  localparam logic [3:0] ST_POP   = 4'd3;
  localparam logic [3:0] ST_POPW  = 4'd4;
  localparam logic [3:0] ST_RD    = 4'd5;
  localparam logic [3:0] ST_CHK   = 4'd6;
  localparam logic [3:0] ST_FLOW  = 4'd7;
  localparam logic [3:0] ST_PAR   = 4'd8;
  localparam logic [3:0] ST_PARW  = 4'd9;
  localparam logic [3:0] ST_FWRD  = 4'd10;
  localparam logic [3:0] ST_FWWR  = 4'd11;
  localparam logic [3:0] ST_BKRD  = 4'd12;
  localparam logic [3:0] ST_BKWR  = 4'd13;
  localparam logic [3:0] ST_DONE  = 4'd14;

  // request fields
  logic [1:0]         cmd;
  logic [NODE_FW-1:0] from_node, to_node, source_node, sink_node;
  logic [15:0]        edge_capacity;
  logic               from_ok, to_ok, src_ok, snk_ok;

  assign cmd           = s_tuser;
  assign from_node     = s_tdata[5:0];
  assign to_node       = s_tdata[11:6];
  assign edge_capacity = s_tdata[27:12];
  assign source_node   = s_tdata[33:28];
  assign sink_node     = s_tdata[39:34];

  assign from_ok = {1'b0, from_node}   < 7'(NODES);
  assign to_ok   = {1'b0, to_node}     < 7'(NODES);
  assign src_ok  = {1'b0, source_node} < 7'(NODES);
  assign snk_ok  = {1'b0, sink_node}   < 7'(NODES);

  // sequencer registers
  logic [3:0]        state;
  logic [AW-1:0]     sweep;
  logic [NW-1:0]     src, snk;
  logic [FLOW_W-1:0] flow;
  logic [NODES-1:0]  reached;
  logic [NW:0]       head, tail;
  logic [NW-1:0]     u, v, cur, prev;
  logic [CAP_W-1:0]  ufl, f;

  // matrix ram ports
  logic             m_we;
  logic [AW-1:0]    m_waddr, m_raddr;
  logic [CAP_W-1:0] m_wdata, m_rdata;

  // bfs queue and parent tables
  logic [CAP_W+NW-1:0] q_mem [NODES];
  logic [CAP_W+NW-1:0] q_rdata, q_wdata;
  logic [NW-1:0]       q_waddr;
  logic                q_we;
  logic [NW-1:0]       p_mem [NODES];
  logic [NW-1:0]       p_rdata;
  logic                p_we;

  // shared alu
  alu_op_t           alu_op;
  logic [FLOW_W-1:0] alu_a, alu_b, alu_y;

  logic accept;
  logic hit;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  // unvisited neighbor with spare capacity
  assign hit      = !reached[v] && (m_rdata != '0);

  mfmc_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  mfmc_mat_ram #(
    .AW (AW),
    .DW (CAP_W)
  ) u_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  // alu operand select
  always_comb begin
    alu_op = OP_MIN;
    alu_a  = FLOW_W'(ufl);
    alu_b  = FLOW_W'(m_rdata);
    unique case (state)
      ST_FLOW: begin
        alu_op = OP_ADD_FLOW;
        alu_a  = flow;
        alu_b  = FLOW_W'(f);
      end
      ST_FWWR: begin
        alu_op = OP_SUB;
        alu_a  = FLOW_W'(m_rdata);
        alu_b  = FLOW_W'(f);
      end
      ST_BKWR: begin
        alu_op = OP_ADD_CAP;
        alu_a  = FLOW_W'(m_rdata);
        alu_b  = FLOW_W'(f);
      end
      default: ;
    endcase
  end

  // matrix ram address and write select
  always_comb begin
    m_we    = 1'b0;
    m_waddr = '0;
    m_wdata = '0;
    m_raddr = '0;
    unique case (state)
      ST_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = sweep;
      end
      ST_IDLE: begin
        m_we    = accept && (cmd == CMD_ADD) && from_ok && to_ok;
        m_waddr = {from_node[NW-1:0], to_node[NW-1:0]};
        m_wdata = CAP_W'(edge_capacity);
      end
      ST_RD:   m_raddr = {u, v};
      ST_FWRD: m_raddr = {prev, cur};
      ST_FWWR: begin
        m_we    = 1'b1;
        m_waddr = {prev, cur};
        m_wdata = alu_y[CAP_W-1:0];
      end
      ST_BKRD: m_raddr = {cur, prev};
      ST_BKWR: begin
        m_we    = 1'b1;
        m_waddr = {cur, prev};
        m_wdata = alu_y[CAP_W-1:0];
      end
      default: ;
    endcase
  end

  // queue and parent writes
  always_comb begin
    q_we    = 1'b0;
    q_waddr = tail[NW-1:0];
    q_wdata = {alu_y[CAP_W-1:0], v};
    p_we    = 1'b0;
    if (state == ST_INIT) begin
      q_we    = 1'b1;
      q_waddr = '0;
      q_wdata = {CAP_MAX, src};
    end else if (state == ST_CHK && hit) begin
      p_we = 1'b1;
      q_we = (v != snk) && (tail < NCNT);
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rdata <= q_mem[head[NW-1:0]];
    if (p_we) begin
      p_mem[v] <= u;
    end
    p_rdata <= p_mem[cur];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      sweep    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // a new report in the done state takes the place of the one handed off
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (&sweep) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_CLEAR: begin
                sweep <= '0;
                state <= ST_CLEAR;
              end
              CMD_RUN: begin
                src  <= source_node[NW-1:0];
                snk  <= sink_node[NW-1:0];
                flow <= '0;
                if (src_ok && snk_ok) begin
                  state <= ST_INIT;
                end else begin
                  reached <= '0;
                  state   <= ST_DONE;
                end
              end
              default: ;
            endcase
          end
        end
        ST_INIT: begin
          reached <= NODES'(1) << src;
          head    <= '0;
          tail    <= (NW + 1)'(1);
          state   <= ST_POP;
        end
        ST_POP: begin
          if (head < tail) begin
            head  <= head + 1'b1;
            state <= ST_POPW;
          end else begin
            // no path left: reached holds the cut side
            state <= ST_DONE;
          end
        end
        ST_POPW: begin
          u     <= q_rdata[NW-1:0];
          ufl   <= q_rdata[CAP_W+NW-1:NW];
          v     <= '0;
          state <= ST_RD;
        end
        ST_RD: state <= ST_CHK;
        ST_CHK: begin
          if (hit) begin
            reached[v] <= 1'b1;
          end
          if (hit && v == snk) begin
            f     <= alu_y[CAP_W-1:0];
            state <= ST_FLOW;
          end else begin
            if (hit && tail < NCNT) begin
              tail <= tail + 1'b1;
            end
            if (v == VLAST) begin
              state <= ST_POP;
            end else begin
              v     <= v + 1'b1;
              state <= ST_RD;
            end
          end
        end
        ST_FLOW: begin
          flow  <= alu_y;
          cur   <= snk;
          state <= ST_PAR;
        end
        ST_PAR: begin
          // walk back along the parent chain
          state <= (cur == src) ? ST_INIT : ST_PARW;
        end
        ST_PARW: begin
          prev  <= p_rdata;
          state <= ST_FWRD;
        end
        ST_FWRD: state <= ST_FWWR;
        ST_FWWR: state <= ST_BKRD;
        ST_BKRD: state <= ST_BKWR;
        ST_BKWR: begin
          cur   <= prev;
          state <= ST_PAR;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, MASK_W'(reached), flow};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/mfmc_checker.sv -----
// port-level checks for the max flow engine, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module mfmc_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_tvalid,
  input wire logic                        s_tready,
  input wire logic [mfmc_pkg::IN_DW-1:0]  s_tdata,
  input wire logic [1:0]                  s_tuser,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [mfmc_pkg::OUT_DW-1:0] m_tdata
);
  import mfmc_pkg::*;

  logic s_fire;

  assign s_fire = s_tvalid && s_tready;

  // clearing pass follows reset
  `ASSERT_IMPL(a_clear_after_rst, $fell(rst), !s_tready)
  // only a run request produces a result
  `ASSERT_NEXT(a_no_result_wo_run, s_fire && s_tuser != CMD_RUN, !$rose(m_tvalid))
  // a result appears only while input side is busy
  `ASSERT_IMPL(a_result_while_busy, $rose(m_tvalid), $past(!s_tready))
  // stalled result holds
  `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // a waiting request holds steady
  `ASSERT_NEXT(a_in_hold, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata))
endmodule

bind max_flow_min_cut_engine_unit mfmc_checker u_mfmc_checker (.*);
`default_nettype wire
